FILE: rtl/dlpf_pkg.sv
`timescale 1ns / 1ps

package dlpf_pkg;

  // payload bytes carried per packet; this lamp's level sits in byte lamp_id/2
  localparam int unsigned PayloadBytes = 16;
  localparam int unsigned PayloadBits  = PayloadBytes * 8;
  localparam int unsigned ByteIdxW     = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;

  localparam logic [15:0] BcastAddr     = 16'hffff;
  localparam int unsigned SeqWindowBits = 28;

  // kind byte layout
  localparam int unsigned ReplyBit      = 7;
  localparam int unsigned FromDimmerBit = 6;

  // command codes, bits 5..0 of kind
  localparam logic [5:0] CmdSetValues   = 6'd0;
  localparam logic [5:0] CmdSetLampId   = 6'd1;
  localparam logic [5:0] CmdWriteConfig = 6'd3;
  localparam logic [5:0] CmdPing        = 6'd8;
  localparam logic [5:0] CmdReset       = 6'd9;
  localparam logic [5:0] CmdUpdateMode  = 6'h3f;

  // update-mode key in payload bytes 0..3
  localparam logic [31:0] UpdateKey = 32'hefbeadde;

  // configuration register indexes
  localparam logic [1:0] RegOwnAddress     = 2'd0;
  localparam logic [1:0] RegInitialLampId  = 2'd1;
  localparam logic [1:0] RegInitialGroupId = 2'd2;

  localparam logic [4:0] NoLevel = 5'h10;

  typedef enum logic [2:0] {
    DROP_NONE    = 3'd0,
    DROP_GROUP   = 3'd1,
    DROP_ADDR    = 3'd2,
    DROP_DIMMER  = 3'd3,
    DROP_SEQ     = 3'd4
  } drop_e;

  typedef struct packed {
    logic [31:0] ping_number;
    logic [7:0]  new_group_id;
    logic [7:0]  new_lamp_id;
    logic [63:0] payload_high;
    logic [63:0] payload_low;
    logic [31:0] sequence_req;
    logic [7:0]  group_id;
    logic [15:0] dest_address;
    logic [7:0]  kind;
  } pkt_t;

  // filter view of the block state
  typedef struct packed {
    logic [15:0] own_address;
    logic [7:0]  group_id_now;
    logic [31:0] last_seq;
  } filt_state_t;

  typedef struct packed {
    logic [31:0] pings_missed;
    logic [31:0] value_packets;
    logic        reply_request;
    logic        update_request;
    logic        reset_request;
    logic        store_request;
    logic [3:0]  level;
    logic        level_update;
    drop_e       drop_reason;
    logic        accepted;
  } res_t;

endpackage

FILE: rtl/dlpf_filter.sv
`timescale 1ns / 1ps

module dlpf_filter (
  input  dlpf_pkg::pkt_t        pkt_i,
  input  dlpf_pkg::filt_state_t st_i,
  output dlpf_pkg::drop_e       reason_o
);

  logic        is_bcast;
  logic [31:0] seq_diff;
  logic        seq_ok;

  assign is_bcast = (pkt_i.dest_address == dlpf_pkg::BcastAddr);
  assign seq_diff = pkt_i.sequence_req - st_i.last_seq;

  // forward window 1 .. 2^28-1, anything goes until seeded
  assign seq_ok = (st_i.last_seq == 32'd0) ||
                  ((seq_diff != 32'd0) && (seq_diff[31:dlpf_pkg::SeqWindowBits] == '0));

  always_comb begin
    if (is_bcast && (pkt_i.group_id != st_i.group_id_now)) begin
      reason_o = dlpf_pkg::DROP_GROUP;
    end else if (!is_bcast && (pkt_i.dest_address != st_i.own_address)) begin
      reason_o = dlpf_pkg::DROP_ADDR;
    end else if (pkt_i.kind[dlpf_pkg::FromDimmerBit]) begin
      reason_o = dlpf_pkg::DROP_DIMMER;
    end else if (!seq_ok) begin
      reason_o = dlpf_pkg::DROP_SEQ;
    end else begin
      reason_o = dlpf_pkg::DROP_NONE;
    end
  end

endmodule

FILE: rtl/dimmer_link_packet_filter.sv
`timescale 1ns / 1ps

// dimmer link packet filter
// s_axis carries one decoded, crc-checked packet per request, its command
// byte on tuser; m_axis returns exactly one result per packet: accept flag,
// drop reason, level change, request flags and the two running counters.
// cfg_we_i/cfg_idx_i/cfg_data_i write own_address (0), initial_lamp_id (1)
// and initial_group_id (2); the id writes load the live ids at once. write
// only while no packet is in flight.
// path: a packet goes through the input register and then the result
// register before its result shows on m_axis; while the result register
// is full and not taken, the packet waits in the input register.
// throughput: one packet per cycle while m_axis_tready stays high; the
// sequence check, level pick and counter updates are combinational between
// the two registers, so back-to-back packets see each other's state updates.
// stall: while m_axis_tready is low a full result register holds; the input
// register still takes one more packet, then s_axis_tready drops.
// reset: all control, counters and sequence/ping history clear, the level
// history goes to "no level yet", own address and ids go to zero.

module dimmer_link_packet_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_address, group_id, sequence_req, payload_low, payload_high,
  // new_lamp_id, new_group_id, ping_number (from bit 0 up)
  input  logic [231:0] s_axis_tdata,
  // kind
  input  logic [7:0]   s_axis_tuser,
  // accepted, drop_reason, level_update, level, store_request,
  // reset_request, update_request, reply_request, value_packets,
  // pings_missed (from bit 0 up), zero pad to 80 bits
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  // input register
  logic           in_valid_q;
  dlpf_pkg::pkt_t in_pkt_q;
  // result register
  logic           out_valid_q;
  dlpf_pkg::res_t out_q, res_d;
  logic           advance;

  // block state
  logic [15:0] own_address_q;
  logic [31:0] last_seq_q, last_seq_d;
  logic [31:0] last_ping_q, last_ping_d;
  logic [31:0] ping_loss_q, ping_loss_d;
  logic [31:0] value_count_q, value_count_d;
  logic [4:0]  prev_level_q, prev_level_d;
  logic [7:0]  lamp_id_q, lamp_id_d;
  logic [7:0]  group_id_q, group_id_d;

  dlpf_pkg::filt_state_t filt_st;
  dlpf_pkg::drop_e       reason;

  logic [5:0]  cmd;
  logic [127:0] payload_all;
  logic [dlpf_pkg::PayloadBytes-1:0][7:0] pay_bytes;
  logic [6:0]  byte_idx;
  logic [7:0]  lamp_byte;
  logic [3:0]  nibble;
  logic        lamp_in_payload;

  // pipeline handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pkt_q <= dlpf_pkg::pkt_t'({s_axis_tdata, s_axis_tuser});
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // address / group / origin / sequence filter
  assign filt_st.own_address  = own_address_q;
  assign filt_st.group_id_now = group_id_q;
  assign filt_st.last_seq     = last_seq_q;

  dlpf_filter u_filter (
    .pkt_i    (in_pkt_q),
    .st_i     (filt_st),
    .reason_o (reason)
  );

  // level pick for set-values
  assign cmd         = in_pkt_q.kind[5:0];
  assign payload_all = {in_pkt_q.payload_high, in_pkt_q.payload_low};
  assign pay_bytes   = payload_all[dlpf_pkg::PayloadBits-1:0];
  assign byte_idx    = lamp_id_q[7:1];
  assign lamp_in_payload = ({25'd0, byte_idx} < 32'(dlpf_pkg::PayloadBytes));
  assign lamp_byte = pay_bytes[byte_idx[dlpf_pkg::ByteIdxW-1:0]];
  assign nibble    = lamp_id_q[0] ? lamp_byte[7:4] : lamp_byte[3:0];

  always_comb begin
    last_seq_d    = last_seq_q;
    last_ping_d   = last_ping_q;
    ping_loss_d   = ping_loss_q;
    value_count_d = value_count_q;
    prev_level_d  = prev_level_q;
    lamp_id_d     = lamp_id_q;
    group_id_d    = group_id_q;
    res_d         = '0;
    res_d.drop_reason = reason;

    if (reason == dlpf_pkg::DROP_NONE) begin
      res_d.accepted      = 1'b1;
      res_d.reply_request = in_pkt_q.kind[dlpf_pkg::ReplyBit];
      last_seq_d          = in_pkt_q.sequence_req;
      case (cmd)
        dlpf_pkg::CmdSetValues: begin
          if (lamp_in_payload) begin
            if ({1'b0, nibble} != prev_level_q) begin
              prev_level_d       = {1'b0, nibble};
              res_d.level_update = 1'b1;
              res_d.level        = nibble;
            end
            value_count_d = value_count_q + 32'd1;
          end
        end
        dlpf_pkg::CmdSetLampId: begin
          if ((in_pkt_q.new_lamp_id != lamp_id_q) || (in_pkt_q.new_group_id != group_id_q)) begin
            lamp_id_d           = in_pkt_q.new_lamp_id;
            group_id_d          = in_pkt_q.new_group_id;
            res_d.store_request = 1'b1;
          end
        end
        dlpf_pkg::CmdWriteConfig: begin
          res_d.store_request = 1'b1;
        end
        dlpf_pkg::CmdPing: begin
          // reseed on first ping or a ping that went backward
          if ((last_ping_q == 32'd0) || (last_ping_q > in_pkt_q.ping_number)) begin
            last_ping_d = in_pkt_q.ping_number;
          end else if (in_pkt_q.ping_number != last_ping_q) begin
            // gap - 1 == ping + ~last_ping
            ping_loss_d = ping_loss_q + in_pkt_q.ping_number + ~last_ping_q;
            last_ping_d = in_pkt_q.ping_number;
          end
        end
        dlpf_pkg::CmdReset: begin
          res_d.reset_request = 1'b1;
        end
        dlpf_pkg::CmdUpdateMode: begin
          res_d.update_request = (in_pkt_q.payload_low[31:0] == dlpf_pkg::UpdateKey) &&
                                 (in_pkt_q.dest_address != dlpf_pkg::BcastAddr);
        end
        default: begin
        end
      endcase
    end

    res_d.value_packets = value_count_d;
    res_d.pings_missed  = ping_loss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= '0;
      last_seq_q    <= '0;
      last_ping_q   <= '0;
      ping_loss_q   <= '0;
      value_count_q <= '0;
      prev_level_q  <= dlpf_pkg::NoLevel;
      lamp_id_q     <= '0;
      group_id_q    <= '0;
    end else begin
      if (advance) begin
        last_seq_q    <= last_seq_d;
        last_ping_q   <= last_ping_d;
        ping_loss_q   <= ping_loss_d;
        value_count_q <= value_count_d;
        prev_level_q  <= prev_level_d;
        lamp_id_q     <= lamp_id_d;
        group_id_q    <= group_id_d;
      end
      // config writes are to come only while idle; the block does not enforce this
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dlpf_pkg::RegOwnAddress:     own_address_q <= cfg_data_i;
          dlpf_pkg::RegInitialLampId:  lamp_id_q     <= cfg_data_i[7:0];
          dlpf_pkg::RegInitialGroupId: group_id_q    <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // a dropped packet raises nothing
  a_drop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.accepted |->
      out_q.drop_reason != dlpf_pkg::DROP_NONE && !out_q.level_update &&
      !out_q.store_request && !out_q.reset_request && !out_q.update_request &&
      !out_q.reply_request)
    else $error("dropped packet carries flags");

  a_accept_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.accepted == (out_q.drop_reason == dlpf_pkg::DROP_NONE))
    else $error("accept flag and drop reason disagree");

  // sequence history moves only with a packet
  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(last_seq_q))
    else $error("last sequence changed without a packet");

  a_value_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (value_count_q == $past(value_count_q)) ||
                (value_count_q == $past(value_count_q) + 32'd1))
    else $error("value counter jumped");

  // a held packet stays in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_pkt_q))
    else $error("input register lost a packet");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// packet filter testbench: a directed walk through the filter and command
// cases, register sweeps across extreme settings, random traffic with random
// idling on both sides, and a long receiver hold that backs the block up.
// every accepted request is scored against an in-bench model of the filter.

module testbench;

  // unlisted command codes and the register index past the end of the list
  localparam logic [5:0] CmdSetGamma = 6'd2;
  localparam logic [5:0] CmdSpare    = 6'h3e;
  localparam logic [1:0] RegUnused   = 2'd3;

  localparam int unsigned StallLimit = 3000;  // cycles with no request moving
  localparam int unsigned LongHold   = 400;   // receiver hold in the fill test

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // dest_address, group_id, sequence_req, payload_low, payload_high,
  // new_lamp_id, new_group_id, ping_number (from bit 0 up)
  logic [231:0] s_axis_tdata = '0;
  // kind
  logic [7:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // accepted, drop_reason, level_update, level, store_request, reset_request,
  // update_request, reply_request, value_packets, pings_missed (from bit 0 up)
  logic [79:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  dimmer_link_packet_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // filter model: registers, live ids and the sequence/ping/level history
  // ---------------------------------------------------------------------
  logic [15:0] cur_own_addr  = '0;
  logic [7:0]  cur_lamp_id   = '0;
  logic [7:0]  cur_group_id  = '0;
  logic [31:0] seen_seq      = '0;   // zero means not seeded yet
  logic [31:0] seen_ping     = '0;   // zero means no ping yet
  logic [31:0] lost_pings    = '0;
  logic [31:0] value_total   = '0;
  logic [4:0]  last_level    = dlpf_pkg::NoLevel;

  dlpf_pkg::res_t expected_verdicts[$];
  int unsigned    mismatches = 0;

  // idling knobs, changed per phase
  int unsigned tx_max_gap = 0;
  int unsigned rx_max_gap = 0;
  int unsigned rx_hold_cycles = 0;

  // runs one packet through the filter and its command, updating the history
  function automatic dlpf_pkg::res_t judge_packet(dlpf_pkg::pkt_t p);
    dlpf_pkg::res_t r;
    logic [5:0]     cmd;
    logic [31:0]    seq_gap;
    logic [127:0]   payload;
    logic [7:0]     lamp_byte;
    logic [3:0]     nibble;
    int unsigned    byte_sel;
    r = '0;
    r.drop_reason = dlpf_pkg::DROP_NONE;
    cmd = p.kind[5:0];
    seq_gap = p.sequence_req - seen_seq;
    payload = {p.payload_high, p.payload_low};
    byte_sel = 32'(cur_lamp_id[7:1]);

    // filters in priority order
    if (p.dest_address == dlpf_pkg::BcastAddr && p.group_id != cur_group_id) begin
      r.drop_reason = dlpf_pkg::DROP_GROUP;
    end else if (p.dest_address != dlpf_pkg::BcastAddr &&
                 p.dest_address != cur_own_addr) begin
      r.drop_reason = dlpf_pkg::DROP_ADDR;
    end else if (p.kind[dlpf_pkg::FromDimmerBit]) begin
      r.drop_reason = dlpf_pkg::DROP_DIMMER;
    end else if (seen_seq != 32'd0 &&
                 (seq_gap == 32'd0 || seq_gap >= (32'd1 << dlpf_pkg::SeqWindowBits))) begin
      r.drop_reason = dlpf_pkg::DROP_SEQ;
    end

    if (r.drop_reason == dlpf_pkg::DROP_NONE) begin
      r.accepted = 1'b1;
      seen_seq = p.sequence_req;
      r.reply_request = p.kind[dlpf_pkg::ReplyBit];
      case (cmd)
        dlpf_pkg::CmdSetValues: begin
          // lamp past the end of the payload: nothing used, nothing counted
          if (byte_sel < dlpf_pkg::PayloadBytes) begin
            lamp_byte = payload[byte_sel*8 +: 8];
            nibble = cur_lamp_id[0] ? lamp_byte[7:4] : lamp_byte[3:0];
            if ({1'b0, nibble} != last_level) begin
              last_level = {1'b0, nibble};
              r.level_update = 1'b1;
              r.level = nibble;
            end
            value_total = value_total + 32'd1;
          end
        end
        dlpf_pkg::CmdSetLampId: begin
          if (p.new_lamp_id != cur_lamp_id || p.new_group_id != cur_group_id) begin
            cur_lamp_id = p.new_lamp_id;
            cur_group_id = p.new_group_id;
            r.store_request = 1'b1;
          end
        end
        dlpf_pkg::CmdWriteConfig: begin
          r.store_request = 1'b1;
        end
        dlpf_pkg::CmdPing: begin
          // reseed on first ping or a step back; equal ping counts nothing
          if (seen_ping == 32'd0 || seen_ping > p.ping_number) begin
            seen_ping = p.ping_number;
          end else if (p.ping_number != seen_ping) begin
            lost_pings = lost_pings + (p.ping_number - seen_ping - 32'd1);
            seen_ping = p.ping_number;
          end
        end
        dlpf_pkg::CmdReset: begin
          r.reset_request = 1'b1;
        end
        dlpf_pkg::CmdUpdateMode: begin
          r.update_request = (p.payload_low[31:0] == dlpf_pkg::UpdateKey) &&
                             (p.dest_address != dlpf_pkg::BcastAddr);
        end
        default: begin
        end
      endcase
    end

    r.value_packets = value_total;
    r.pings_missed = lost_pings;
    return r;
  endfunction

  function automatic logic [7:0] make_kind(logic reply, logic from_dimmer, logic [5:0] cmd);
    logic [7:0] k;
    k = '0;
    k[dlpf_pkg::ReplyBit] = reply;
    k[dlpf_pkg::FromDimmerBit] = from_dimmer;
    k[5:0] = cmd;
    return k;
  endfunction

  function automatic dlpf_pkg::pkt_t quiet_packet(logic [7:0] kind, logic [15:0] dest,
                                                  logic [7:0] grp, logic [31:0] seq);
    dlpf_pkg::pkt_t p;
    p = '0;
    p.kind = kind;
    p.dest_address = dest;
    p.group_id = grp;
    p.sequence_req = seq;
    return p;
  endfunction

  // mostly well-formed packets aimed at this lamp, with some noise mixed in
  function automatic dlpf_pkg::pkt_t random_packet();
    dlpf_pkg::pkt_t p;
    int unsigned    pick;
    logic [5:0]     cmd;
    p.payload_low  = {$urandom, $urandom};
    p.payload_high = {$urandom, $urandom};
    p.new_lamp_id  = 8'($urandom);
    p.new_group_id = 8'($urandom);
    p.ping_number  = $urandom;
    p.sequence_req = $urandom;
    p.group_id     = 8'($urandom);
    p.dest_address = 16'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 30)      cmd = dlpf_pkg::CmdSetValues;
    else if (pick < 42) cmd = dlpf_pkg::CmdSetLampId;
    else if (pick < 50) cmd = dlpf_pkg::CmdWriteConfig;
    else if (pick < 68) cmd = dlpf_pkg::CmdPing;
    else if (pick < 74) cmd = dlpf_pkg::CmdReset;
    else if (pick < 84) cmd = dlpf_pkg::CmdUpdateMode;
    else                cmd = 6'($urandom);
    p.kind = make_kind(1'($urandom_range(0, 1)), ($urandom_range(0, 19) == 0), cmd);

    pick = $urandom_range(0, 99);
    if (pick < 45)      p.dest_address = cur_own_addr;
    else if (pick < 85) p.dest_address = dlpf_pkg::BcastAddr;
    if ($urandom_range(0, 9) != 0) p.group_id = cur_group_id;

    // sequence: mostly a small step forward, some at and past the window edge
    if (seen_seq != 32'd0) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        p.sequence_req = seen_seq + $urandom_range(1, 1000);
      end else if (pick < 85) begin
        p.sequence_req = seen_seq + (32'd1 << dlpf_pkg::SeqWindowBits) -
                         $urandom_range(1, 3);
      end else if (pick < 90) begin
        p.sequence_req = seen_seq + (32'd1 << dlpf_pkg::SeqWindowBits) +
                         $urandom_range(0, 3);
      end else if (pick < 95) begin
        p.sequence_req = seen_seq;
      end
    end

    case (cmd)
      dlpf_pkg::CmdSetLampId: begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          p.new_lamp_id = cur_lamp_id;
          p.new_group_id = cur_group_id;
        end else if (pick < 85) begin
          p.new_lamp_id = 8'($urandom_range(0, 33));
          if ($urandom_range(0, 9) < 7) p.new_group_id = cur_group_id;
        end
      end
      dlpf_pkg::CmdPing: begin
        if ($urandom_range(0, 9) < 7) p.ping_number = seen_ping + $urandom_range(0, 16);
      end
      dlpf_pkg::CmdUpdateMode: begin
        if ($urandom_range(0, 9) < 6) p.payload_low[31:0] = dlpf_pkg::UpdateKey;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // sender side: one request per call, random gap in front of it
  // ---------------------------------------------------------------------
  task automatic send_packet(dlpf_pkg::pkt_t p);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.kind;
    s_axis_tdata <= p[$bits(dlpf_pkg::pkt_t)-1:8];
    do @(posedge clk_i); while (!s_axis_tready);
    expected_verdicts.push_back(judge_packet(p));
  endtask

  // stop offering, then wait for every outstanding verdict
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // the write lands at the rising edge between raising and dropping cfg_we_i
  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      dlpf_pkg::RegOwnAddress:     cur_own_addr = data;
      dlpf_pkg::RegInitialLampId:  cur_lamp_id = data[7:0];
      dlpf_pkg::RegInitialGroupId: cur_group_id = data[7:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random hold before each result, or a long hold on demand
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = $urandom_range(0, rx_max_gap);
      end
      repeat (hold) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------
  // result check: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    dlpf_pkg::res_t got;
    dlpf_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = dlpf_pkg::res_t'(m_axis_tdata[$bits(dlpf_pkg::res_t)-1:0]);
      if (expected_verdicts.size() == 0) begin
        $error("result with no packet outstanding: 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        compare_field("accepted",       32'(want.accepted),       32'(got.accepted));
        compare_field("drop_reason",    32'(want.drop_reason),    32'(got.drop_reason));
        compare_field("level_update",   32'(want.level_update),   32'(got.level_update));
        compare_field("level",          32'(want.level),          32'(got.level));
        compare_field("store_request",  32'(want.store_request),  32'(got.store_request));
        compare_field("reset_request",  32'(want.reset_request),  32'(got.reset_request));
        compare_field("update_request", 32'(want.update_request), 32'(got.update_request));
        compare_field("reply_request",  32'(want.reply_request),  32'(got.reply_request));
        compare_field("value_packets",  want.value_packets,       got.value_packets);
        compare_field("pings_missed",   want.pings_missed,        got.pings_missed);
      end
    end
  end

  // watchdog: too long without any request moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no request moved for %0d cycles", StallLimit);
    $display("[dimmer_link_packet_filter] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // walk through every filter, every command and the history corner cases
  // with reset defaults: own address 0, lamp 0, group 0
  task automatic test_directed();
    dlpf_pkg::pkt_t p;
    logic [31:0]    seq;
    tx_max_gap = 3;
    rx_max_gap = 3;

    // the three address/origin filters
    send_packet(quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues),
                             dlpf_pkg::BcastAddr, 8'd5, 32'd1));
    send_packet(quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues),
                             16'h1234, 8'd0, 32'd1));
    send_packet(quiet_packet(make_kind(1'b1, 1'b1, dlpf_pkg::CmdSetValues),
                             16'h0000, 8'd0, 32'd1));

    // unseeded: sequence 0 passes and leaves the history unseeded; first level
    send_packet(quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues),
                             dlpf_pkg::BcastAddr, 8'd0, 32'd0));

    // seed near the top so the next steps wrap around zero
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues), 16'h0000, 8'd0,
                     32'hffff_fff0);
    p.payload_low = 64'h3;
    send_packet(p);
    send_packet(p);                 // same sequence again: dropped
    p.sequence_req = 32'h0000_0010; // forward across the wrap, same level
    send_packet(p);
    // window edge: one past is dropped, one short is taken
    seq = 32'h0000_0010 + (32'd1 << dlpf_pkg::SeqWindowBits);
    send_packet(quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues),
                             16'h0000, 8'd0, seq));
    seq = seq - 32'd1;
    p = quiet_packet(make_kind(1'b1, 1'b0, dlpf_pkg::CmdSetValues), 16'h0000, 8'd0, seq);
    p.payload_low = 64'hffff_ffff_ffff_ffff;
    send_packet(p);

    // set-lamp-id: unchanged ids, then the top nibble of the last payload byte
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetLampId), 16'h0000, 8'd0, ++seq);
    send_packet(p);
    p.sequence_req = ++seq;
    p.new_lamp_id = 8'd31;
    p.new_group_id = 8'd7;
    send_packet(p);
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues), dlpf_pkg::BcastAddr,
                     8'd7, ++seq);
    p.payload_high = 64'ha500_0000_0000_0000;
    send_packet(p);

    // lamp just past the payload: set-values is not counted
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetLampId), 16'h0000, 8'd0, ++seq);
    p.new_lamp_id = 8'd32;
    p.new_group_id = 8'd7;
    send_packet(p);
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdSetValues), 16'h0000, 8'd0, ++seq);
    p.payload_low = '1;
    p.payload_high = '1;
    send_packet(p);

    send_packet(quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdWriteConfig),
                             16'h0000, 8'd0, ++seq));

    // pings: zero, reseed from none, equal, a gap, step back, top value
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdPing), 16'h0000, 8'd0, ++seq);
    send_packet(p);
    p.sequence_req = ++seq; p.ping_number = 32'd10;          send_packet(p);
    p.sequence_req = ++seq;                                  send_packet(p);
    p.sequence_req = ++seq; p.ping_number = 32'd15;          send_packet(p);
    p.sequence_req = ++seq; p.ping_number = 32'd3;           send_packet(p);
    p.sequence_req = ++seq; p.ping_number = 32'hffff_ffff;   send_packet(p);

    send_packet(quiet_packet(make_kind(1'b1, 1'b0, dlpf_pkg::CmdReset),
                             16'h0000, 8'd0, ++seq));

    // update mode: unicast with key, broadcast with key, unicast wrong key
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdUpdateMode), 16'h0000, 8'd0, ++seq);
    p.payload_low = {32'h0, dlpf_pkg::UpdateKey};
    send_packet(p);
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdUpdateMode), dlpf_pkg::BcastAddr,
                     8'd7, ++seq);
    p.payload_low = {32'h0, dlpf_pkg::UpdateKey};
    send_packet(p);
    p = quiet_packet(make_kind(1'b0, 1'b0, dlpf_pkg::CmdUpdateMode), 16'h0000, 8'd0, ++seq);
    p.payload_low = {32'h0, dlpf_pkg::UpdateKey ^ 32'h0100_0000};
    send_packet(p);

    // commands that only report the reply flag
    send_packet(quiet_packet(make_kind(1'b1, 1'b0, CmdSetGamma), 16'h0000, 8'd0, ++seq));
    send_packet(quiet_packet(make_kind(1'b0, 1'b0, CmdSpare), dlpf_pkg::BcastAddr,
                             8'd7, ++seq));
    settle_block();
  endtask

  // several register settings, extremes first, random traffic under each
  task automatic test_register_sweep();
    logic [15:0] own_list[8]   = '{16'h0000, 16'hffff, 16'hfffe, 16'h0001,
                                   16'h8000, 16'h7fff, 16'h0000, 16'h0000};
    logic [7:0]  lamp_list[8]  = '{8'd0, 8'd255, 8'd31, 8'd30,
                                   8'd1, 8'd254, 8'd0, 8'd0};
    logic [7:0]  group_list[8] = '{8'd0, 8'd255, 8'd128, 8'd1,
                                   8'd7, 8'd254, 8'd0, 8'd0};
    logic [15:0] own;
    logic [7:0]  lamp;
    logic [7:0]  grp;
    for (int phase = 0; phase < 8; phase++) begin
      own = (phase >= 6) ? 16'($urandom) : own_list[phase];
      lamp = (phase >= 6) ? 8'($urandom_range(0, 33)) : lamp_list[phase];
      grp = (phase >= 6) ? 8'($urandom) : group_list[phase];
      // upper data bits are don't-care for the id registers
      write_register(dlpf_pkg::RegOwnAddress, own);
      write_register(dlpf_pkg::RegInitialLampId, {8'($urandom), lamp});
      write_register(dlpf_pkg::RegInitialGroupId, {8'($urandom), grp});
      write_register(RegUnused, 16'($urandom));
      tx_max_gap = (phase % 3 == 0) ? 0 : 7;
      rx_max_gap = (phase % 3 == 1) ? 0 : 7;
      repeat (150) send_packet(random_packet());
      settle_block();
    end
  endtask

  // random traffic, idling pattern changes every 50 packets
  task automatic test_random_mix();
    for (int burst = 0; burst < 6; burst++) begin
      tx_max_gap = (burst % 2 == 0) ? 7 : 0;
      rx_max_gap = (burst % 3 == 0) ? 0 : 7;
      repeat (50) send_packet(random_packet());
    end
    settle_block();
  endtask

  // receiver holds off for a long stretch while packets keep coming, so the
  // block fills and pushes back on its input
  task automatic test_stall_fill();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold_cycles = LongHold;
    repeat (50) send_packet(random_packet());
    rx_max_gap = 7;
    settle_block();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_sweep();
    test_random_mix();
    test_stall_fill();

    repeat (10) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[dimmer_link_packet_filter] OK");
    end else begin
      $display("[dimmer_link_packet_filter] ERROR");
    end
    $finish;
  end

endmodule
